/* design/psrle_pkg.sv */
// psrle_pkg: types, codes and constants shared by the pixel stream run-length encoder
// used by psrle_front, psrle_queue, psrle_back and pixel_stream_run_length_encoder
// no dependencies

package psrle_pkg;

   localparam int MAX_WORDS = 6;
   localparam int CNT_W     = 3;
   localparam int WORD_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MONO_THRESHOLD = 1'd1;

   // mode codes
   localparam logic [1:0] MODE_RAW565 = 2'd0;
   localparam logic [1:0] MODE_RLE555 = 2'd1;
   localparam logic [1:0] MODE_MONO   = 2'd2;

   localparam logic [7:0]        THRESH_RESET = 8'd128;
   localparam logic [WORD_W-1:0] RUN_FLAG     = 16'h0020;
   localparam logic [WORD_W-1:0] RUN_LIMIT    = 16'hFFFD;
   localparam logic [WORD_W-1:0] TERMINATOR   = 16'hFFFF;
   localparam logic [WORD_W-1:0] MONO_LIMIT   = 16'd32767;
   localparam logic [WORD_W-1:0] MONO_SHORT   = 16'd128;
   localparam logic [7:0]        LONG_FLAG    = 8'h80;

   // all words that one pixel causes, in output order
   typedef struct packed {
      logic [MAX_WORDS-1:0][WORD_W-1:0] words;
      logic [CNT_W-1:0]                 count;
   } psrle_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } psrle_q_status_type;

endpackage

/* design/psrle_front.sv */
// psrle_front: accepts pixels, holds config and run state, builds the word list per pixel
// depends on psrle_pkg

module psrle_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_red,
   input  logic [7:0]                           req_green,
   input  logic [7:0]                           req_blue,
   input  logic                                 req_last_pixel,
   input  logic                                 csr_valid,
   input  logic [psrle_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psrle_pkg::CSR_DAT_W-1:0]      csr_data,
   input  psrle_pkg::psrle_q_status_type        q_status,
   output logic                                 q_push,
   output psrle_pkg::psrle_desc_type            q_desc
);

   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  thresh_ff, thresh_in;
   logic [15:0] run_value_ff, run_value_in;
   logic [15:0] run_length_ff, run_length_in;
   logic        mono_level_ff, mono_level_in;
   logic        in_image_ff, in_image_in;
   logic        accept;
   psrle_pkg::psrle_desc_type desc;

   function automatic psrle_pkg::psrle_desc_type add_word(
      input psrle_pkg::psrle_desc_type d, input logic [15:0] w);
      psrle_pkg::psrle_desc_type r;
      r = d;
      r.words[d.count] = w;
      r.count = d.count + 3'd1;
      return r;
   endfunction

   // one byte below 128, else flag byte with high bits then low byte
   function automatic psrle_pkg::psrle_desc_type add_mono_len(
      input psrle_pkg::psrle_desc_type d, input logic [15:0] len);
      psrle_pkg::psrle_desc_type r;
      r = d;
      if (len < psrle_pkg::MONO_SHORT) begin
         r = add_word(r, len);
      end else begin
         r = add_word(r, {8'h00, psrle_pkg::LONG_FLAG | len[15:8]});
         r = add_word(r, {8'h00, len[7:0]});
      end
      return r;
   endfunction

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      logic [15:0] pix;
      logic [15:0] rv;
      logic [15:0] rl;
      logic        ml;
      logic        bit_v;
      psrle_pkg::psrle_desc_type d;
      rv       = run_value_ff;
      rl       = run_length_ff;
      ml       = mono_level_ff;
      pix      = 16'h0000;
      bit_v    = 1'b0;
      d.words  = '0;
      d.count  = '0;
      unique case (mode_ff)
         psrle_pkg::MODE_RLE555: begin
            pix = {req_red[7:3], req_green[7:3], 1'b0, req_blue[7:3]};
            if (!in_image_ff) begin
               rv = pix;
               rl = 16'd0;
            end
            if (rv != pix || rl >= psrle_pkg::RUN_LIMIT) begin
               if (rl > 16'd1) begin
                  d = add_word(d, rv | psrle_pkg::RUN_FLAG);
                  d = add_word(d, rl);
               end else if (rl == 16'd1) begin
                  d = add_word(d, rv);
               end
               rv = pix;
               rl = 16'd1;
            end else begin
               rl = rl + 16'd1;
            end
            if (req_last_pixel) begin
               if (rl != 16'd0) begin
                  d = add_word(d, rv | psrle_pkg::RUN_FLAG);
                  d = add_word(d, rl);
               end
               d = add_word(d, psrle_pkg::TERMINATOR);
               d = add_word(d, psrle_pkg::TERMINATOR);
            end
         end
         psrle_pkg::MODE_MONO: begin
            bit_v = (req_green >= thresh_ff);
            if (bit_v == ml && rl < psrle_pkg::MONO_LIMIT) begin
               rl = rl + 16'd1;
            end else if (bit_v == ml) begin
               // run at its limit: close it with an empty run of the other color
               d  = add_mono_len(d, rl);
               d  = add_word(d, 16'h0000);
               rl = 16'd1;
            end else begin
               d  = add_mono_len(d, rl);
               rl = 16'd1;
               ml = !ml;
            end
            if (req_last_pixel && rl != 16'd0) begin
               d = add_mono_len(d, rl);
            end
         end
         default: begin
            pix = {req_red[7:3], req_green[7:2], req_blue[7:3]};
            d   = add_word(d, pix);
         end
      endcase
      desc          = d;
      run_value_in  = rv;
      run_length_in = rl;
      mono_level_in = ml;
      in_image_in   = 1'b1;
      if (req_last_pixel) begin
         run_value_in  = 16'd0;
         run_length_in = 16'd0;
         mono_level_in = 1'b0;
         in_image_in   = 1'b0;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      thresh_in = thresh_ff;
      if (csr_valid) begin
         unique case (csr_index)
            psrle_pkg::CSR_MODE:           mode_in   = csr_data[1:0];
            psrle_pkg::CSR_MONO_THRESHOLD: thresh_in = csr_data;
            default:                       mode_in   = mode_ff;
         endcase
      end
   end

   assign q_push = accept && (desc.count != '0);
   assign q_desc = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= psrle_pkg::MODE_RAW565;
         thresh_ff     <= psrle_pkg::THRESH_RESET;
         run_value_ff  <= 16'd0;
         run_length_ff <= 16'd0;
         mono_level_ff <= 1'b0;
         in_image_ff   <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         thresh_ff <= thresh_in;
         if (accept) begin
            run_value_ff  <= run_value_in;
            run_length_ff <= run_length_in;
            mono_level_ff <= mono_level_in;
            in_image_ff   <= in_image_in;
         end
      end
   end

endmodule

/* design/psrle_queue.sv */
// psrle_queue: two-entry queue of word lists between front and back
// depends on psrle_pkg

module psrle_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  psrle_pkg::psrle_desc_type     push_desc,
   input  logic                          pop,
   output psrle_pkg::psrle_desc_type     head_desc,
   output psrle_pkg::psrle_q_status_type status
);

   psrle_pkg::psrle_desc_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign head_desc    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/psrle_back.sv */
// psrle_back: walks each queued word list and drives the registered result channel
// depends on psrle_pkg

module psrle_back (
   input  logic                                clock,
   input  logic                                reset,
   input  psrle_pkg::psrle_desc_type           head_desc,
   input  psrle_pkg::psrle_q_status_type       q_status,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [psrle_pkg::WORD_W-1:0]        rsp_out_word,
   output logic                                rsp_last_of_item
);

   logic [psrle_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic                         valid_ff, valid_in;
   logic [psrle_pkg::WORD_W-1:0] word_ff;
   logic                         last_ff;
   logic                         load;
   logic                         last_word;

   assign load      = !q_status.empty && (!valid_ff || !rsp_stall);
   assign last_word = (idx_ff == head_desc.count - 3'd1);
   assign pop       = load && last_word;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_word ? '0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= head_desc.words[idx_ff];
         last_ff <= last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_word     = word_ff;
   assign rsp_last_of_item = last_ff;

endmodule

/* design/pixel_stream_run_length_encoder.sv */
// pixel_stream_run_length_encoder: top level of the pixel stream run-length encoder
// depends on psrle_pkg, psrle_front, psrle_queue and psrle_back
//
// usage
//  - req channel: one rgb pixel per word, raster order, req_last_pixel on the image's last pixel
//  - rsp channel: coded words, rsp_last_of_item marks the final word that a pixel causes
//  - csr channel: index 0 mode (0 rgb565, 1 rgb555 runs, 2 mono runs), index 1 mono threshold;
//    csr_ready is always high, writes are meant for idle periods between images
//  - a pixel may cause zero to six words; pixels that cause none are absorbed by the front
//  - a taken pixel's word list is written into the queue, then its first word is loaded into the
//    output register of the back and is valid on rsp, unless a stalled rsp word still holds it
//  - throughput: one result word per cycle while rsp_stall is low, set by the single output
//    register of the back; a pixel's words leave in order, unstalled one-word pixels go every cycle
//  - the front classifies and updates run state in the cycle it takes a pixel, then parks
//    the word list in a two-entry queue; req_stall rises only while that queue is full
//  - a stalled rsp word holds; the queue keeps taking pixels until it fills
//  - reset: synchronous, clears queue, output valid and run state; mode 0, threshold 128

module pixel_stream_run_length_encoder (
   input  logic                              clock,
   input  logic                              reset,
   // pixel input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_red,
   input  logic [7:0]                        req_green,
   input  logic [7:0]                        req_blue,
   input  logic                              req_last_pixel,
   // coded word output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_out_word,
   output logic                              rsp_last_of_item,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [psrle_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psrle_pkg::CSR_DAT_W-1:0]   csr_data
);

   psrle_pkg::psrle_q_status_type q_status;
   psrle_pkg::psrle_desc_type     push_desc;
   psrle_pkg::psrle_desc_type     head_desc;
   logic                          q_push;
   logic                          q_pop;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // front: pixel intake, config, run tracking
   psrle_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .csr_valid      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_desc         (push_desc)
   );

   // word lists waiting for the back
   psrle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   // back: one word per cycle into the output register while rsp_stall is low
   psrle_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_desc        (head_desc),
      .q_status         (q_status),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_word     (rsp_out_word),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // no push into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full queue");

   // a queued word list holds one to six words
   a_desc_count: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (push_desc.count != 3'd0 && push_desc.count <= 3'd6))
      else $error("bad word count");

   // no pop from an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // output is idle right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule
